### hw/rtl/tis_pkg.sv
package tis_pkg;

    localparam int SYMBOLS_DEF   = 26;
    localparam int MAX_NODES_DEF = 256;
    localparam int MAX_WORDS_DEF = 32;
    localparam int ID_BITS_DEF   = 16;

    localparam logic [1:0] OP_INS_GIVEN = 2'd0;
    localparam logic [1:0] OP_INS_AUTO  = 2'd1;
    localparam logic [1:0] OP_EXACT     = 2'd2;
    localparam logic [1:0] OP_PREFIX    = 2'd3;

    typedef enum logic [2:0] {
        ST_INSERTED   = 3'd0,
        ST_FOUND      = 3'd1,
        ST_NOMATCH    = 3'd2,
        ST_WORDS_FULL = 3'd3,
        ST_NODES_FULL = 3'd4
    } status_t;

    // the no-failure code is the same as that of a successful insert
    localparam logic [2:0] FAIL_NONE = 3'd0;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_END,
        S_FIN,
        S_LRD,
        S_LOUT
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [4:0]  symbol;
        logic        has_symbol;
        logic        end_of_word;
        logic [15:0] given_id;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] word_id;
        logic        last_result;
        logic [8:0]  node_count;
        logic [5:0]  word_count;
    } out_item_t;

endpackage

### hw/rtl/trie_insert_and_search_unit.sv
// Trie word store: insert words and look them up by exact word or prefix.
// Input channel s_*: one request per symbol; the first request of a word
// sets the operation (and the id for an insert with given id), the request
// with end_of_word set closes it. Output channel m_*: results appear only
// at the end of a word, one for an insert, one or more for a search; the
// final one carries last_result.
// Steps: a request with an active symbol reads the child table and length
// entry, then writes back in S_READ; a request without one is handled in
// S_IDLE alone. The end of a word reads the lengths in S_END, and a search
// hit then reads the list memory in S_LRD once for each returned id.
// Reset: while aresetn is low the block is held; once it rises, a clearing
// pass writes zero to every child and length entry, one per cycle; s_ready
// stays low until it ends.
// Stall: one output register holds a result until m_ready takes it; the
// block keeps taking symbol requests meanwhile and waits only when it has
// a new result to show.
module trie_insert_and_search_unit #(
    parameter int SYMBOLS   = tis_pkg::SYMBOLS_DEF,
    parameter int MAX_NODES = tis_pkg::MAX_NODES_DEF,
    parameter int MAX_WORDS = tis_pkg::MAX_WORDS_DEF,
    parameter int ID_BITS   = tis_pkg::ID_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tis_pkg::in_item_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output tis_pkg::out_item_t m_payload
);

    localparam int CDEPTH     = SYMBOLS * MAX_NODES;
    localparam int CA_BITS    = $clog2(CDEPTH);
    localparam int NODE_BITS  = $clog2(MAX_NODES);
    localparam int CNT_BITS   = $clog2(MAX_NODES + 1);
    localparam int LEN_BITS   = $clog2(MAX_WORDS + 1);
    localparam int LDEPTH     = MAX_NODES * MAX_WORDS;
    localparam int LA_BITS    = $clog2(LDEPTH);

    tis_pkg::state_t state_reg, state_next;
    logic [NODE_BITS-1:0] cursor_reg, cursor_next;
    logic [1:0]           mode_reg, mode_next;
    logic [ID_BITS-1:0]   id_reg, id_next;
    logic [2:0]           fail_reg, fail_next;
    logic                 in_word_reg, in_word_next;
    logic                 eow_reg, eow_next;
    logic [CNT_BITS-1:0]  nodes_reg, nodes_next;
    logic [LEN_BITS-1:0]  root_len_reg, root_len_next;
    logic [LEN_BITS-1:0]  cnt_reg, cnt_next;
    logic [LEN_BITS-1:0]  idx_reg, idx_next;
    logic [CA_BITS-1:0]   caddr_reg, caddr_next;
    logic [CA_BITS-1:0]   clr_reg, clr_next;
    logic                 m_valid_reg, m_valid_next;
    tis_pkg::out_item_t   m_payload_reg, m_payload_next;

    logic                 c_we, c_re;
    logic [CA_BITS-1:0]   c_waddr, c_raddr;
    logic [NODE_BITS-1:0] c_wdata, c_rdata;
    logic                 n_we, n_re;
    logic [NODE_BITS-1:0] n_waddr, n_raddr;
    logic [2*LEN_BITS-1:0] n_wdata, n_rdata;
    logic                 p_we, a_we, l_re;
    logic [LA_BITS-1:0]   p_waddr, a_waddr, l_raddr;
    logic [ID_BITS-1:0]   p_rdata, a_rdata;

    logic                 out_free, first, act, inserting, full_nodes;
    logic [LEN_BITS-1:0]  plen, alen, cnt_sel;
    logic [NODE_BITS-1:0] cur_eff;

    tis_ram #(.DEPTH(CDEPTH), .WIDTH(NODE_BITS)) u_child (
        .aclk(aclk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .re(c_re), .raddr(c_raddr), .rdata(c_rdata)
    );
    tis_ram #(.DEPTH(MAX_NODES), .WIDTH(2*LEN_BITS)) u_lens (
        .aclk(aclk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .re(n_re), .raddr(n_raddr), .rdata(n_rdata)
    );
    tis_ram #(.DEPTH(LDEPTH), .WIDTH(ID_BITS)) u_pass (
        .aclk(aclk), .we(p_we), .waddr(p_waddr), .wdata(id_reg),
        .re(l_re), .raddr(l_raddr), .rdata(p_rdata)
    );
    tis_ram #(.DEPTH(LDEPTH), .WIDTH(ID_BITS)) u_accept (
        .aclk(aclk), .we(a_we), .waddr(a_waddr), .wdata(id_reg),
        .re(l_re), .raddr(l_raddr), .rdata(a_rdata)
    );

    assign plen       = n_rdata[LEN_BITS-1:0];
    assign alen       = n_rdata[2*LEN_BITS-1:LEN_BITS];
    assign inserting  = (mode_reg == tis_pkg::OP_INS_GIVEN) || (mode_reg == tis_pkg::OP_INS_AUTO);
    assign out_free   = !m_valid_reg || m_ready;
    assign full_nodes = 32'(nodes_reg) >= MAX_NODES;
    assign s_ready    = (state_reg == tis_pkg::S_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_payload  = m_payload_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tis_pkg::S_CLEAR;
            cursor_reg   <= '0;
            mode_reg     <= '0;
            id_reg       <= '0;
            fail_reg     <= tis_pkg::FAIL_NONE;
            in_word_reg  <= 1'b0;
            eow_reg      <= 1'b0;
            nodes_reg    <= CNT_BITS'(1);
            root_len_reg <= '0;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            clr_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cursor_reg   <= cursor_next;
            mode_reg     <= mode_next;
            id_reg       <= id_next;
            fail_reg     <= fail_next;
            in_word_reg  <= in_word_next;
            eow_reg      <= eow_next;
            nodes_reg    <= nodes_next;
            root_len_reg <= root_len_next;
            cnt_reg      <= cnt_next;
            idx_reg      <= idx_next;
            clr_reg      <= clr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        caddr_reg     <= caddr_next;
        m_payload_reg <= m_payload_next;
    end

    always_comb begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        mode_next      = mode_reg;
        id_next        = id_reg;
        fail_next      = fail_reg;
        in_word_next   = in_word_reg;
        eow_next       = eow_reg;
        nodes_next     = nodes_reg;
        root_len_next  = root_len_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        caddr_next     = caddr_reg;
        clr_next       = clr_reg;
        m_valid_next   = m_ready ? 1'b0 : m_valid_reg;
        m_payload_next = m_payload_reg;
        c_we = 1'b0; c_re = 1'b0; c_waddr = caddr_reg; c_wdata = '0;
        c_raddr = '0;
        n_we = 1'b0; n_re = 1'b0; n_waddr = cursor_reg; n_wdata = n_rdata;
        n_raddr = cursor_reg;
        p_we = 1'b0; a_we = 1'b0;
        p_waddr = LA_BITS'(LA_BITS'(cursor_reg) * MAX_WORDS + LA_BITS'(plen));
        a_waddr = LA_BITS'(LA_BITS'(cursor_reg) * MAX_WORDS + LA_BITS'(alen));
        l_re    = 1'b0;
        l_raddr = LA_BITS'(LA_BITS'(cursor_reg) * MAX_WORDS + LA_BITS'(idx_reg));
        first   = !in_word_reg;
        act     = 1'b0;
        cur_eff = cursor_reg;
        cnt_sel = '0;

        case (state_reg)
            tis_pkg::S_CLEAR: begin
                c_we    = 1'b1;
                c_waddr = clr_reg;
                if (32'(clr_reg) < MAX_NODES) begin
                    n_we    = 1'b1;
                    n_waddr = NODE_BITS'(clr_reg);
                    n_wdata = '0;
                end
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == CDEPTH - 1) begin
                    state_next = tis_pkg::S_IDLE;
                end
            end
            tis_pkg::S_IDLE: begin
                if (s_valid) begin
                    in_word_next = 1'b1;
                    eow_next     = s_payload.end_of_word;
                    if (first) begin
                        mode_next = s_payload.operation;
                        cur_eff   = '0;
                        id_next   = (s_payload.operation == tis_pkg::OP_INS_GIVEN)
                                  ? ID_BITS'(s_payload.given_id) : ID_BITS'(root_len_reg);
                        fail_next = ((s_payload.operation == tis_pkg::OP_INS_GIVEN ||
                                      s_payload.operation == tis_pkg::OP_INS_AUTO) &&
                                     32'(root_len_reg) >= MAX_WORDS)
                                  ? 3'(tis_pkg::ST_WORDS_FULL) : tis_pkg::FAIL_NONE;
                    end
                    cursor_next = cur_eff;
                    act = s_payload.has_symbol && (32'(s_payload.symbol) < SYMBOLS) &&
                          (fail_next == tis_pkg::FAIL_NONE);
                    caddr_next = CA_BITS'(CA_BITS'(cur_eff) * SYMBOLS +
                                          CA_BITS'(s_payload.symbol));
                    if (act) begin
                        c_re       = 1'b1;
                        c_raddr    = caddr_next;
                        n_re       = 1'b1;
                        n_raddr    = cur_eff;
                        state_next = tis_pkg::S_READ;
                    end else if (s_payload.end_of_word) begin
                        state_next = tis_pkg::S_END;
                    end
                end
            end
            tis_pkg::S_READ: begin
                if (inserting) begin
                    cur_eff = c_rdata;
                    if (c_rdata == '0) begin
                        if (full_nodes) begin
                            fail_next = 3'(tis_pkg::ST_NODES_FULL);
                        end else begin
                            cur_eff    = NODE_BITS'(nodes_reg);
                            c_we       = 1'b1;
                            c_wdata    = NODE_BITS'(nodes_reg);
                            nodes_next = nodes_reg + 1'b1;
                        end
                    end
                    if (fail_next == tis_pkg::FAIL_NONE) begin
                        if (32'(plen) < MAX_WORDS) begin
                            p_we    = 1'b1;
                            n_we    = 1'b1;
                            n_wdata = {alen, plen + 1'b1};
                            if (cursor_reg == '0) begin
                                root_len_next = plen + 1'b1;
                            end
                        end
                        cursor_next = cur_eff;
                    end
                end else begin
                    if (c_rdata == '0) begin
                        fail_next = 3'(tis_pkg::ST_NOMATCH);
                    end else begin
                        cursor_next = c_rdata;
                    end
                end
                state_next = eow_reg ? tis_pkg::S_END : tis_pkg::S_IDLE;
            end
            tis_pkg::S_END: begin
                n_re       = 1'b1;
                state_next = tis_pkg::S_FIN;
            end
            tis_pkg::S_FIN: begin
                cnt_sel = (mode_reg == tis_pkg::OP_PREFIX) ? plen : alen;
                if (inserting || fail_reg != tis_pkg::FAIL_NONE || cnt_sel == '0) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_payload_next.last_result = 1'b1;
                        m_payload_next.node_count  = 9'(nodes_reg);
                        m_payload_next.word_count  = 6'(root_len_reg);
                        m_payload_next.word_id     = 16'(id_reg);
                        m_payload_next.status      = fail_reg;
                        if (!inserting) begin
                            m_payload_next.status  = 3'(tis_pkg::ST_NOMATCH);
                            m_payload_next.word_id = '0;
                        end else if (fail_reg == tis_pkg::FAIL_NONE) begin
                            m_payload_next.status = 3'(tis_pkg::ST_INSERTED);
                            n_we    = 1'b1;
                            n_wdata = n_rdata;
                            if (32'(plen) < MAX_WORDS) begin
                                p_we = 1'b1;
                                n_wdata[LEN_BITS-1:0] = plen + 1'b1;
                                if (cursor_reg == '0) begin
                                    root_len_next = plen + 1'b1;
                                    m_payload_next.word_count = 6'(plen + 1'b1);
                                end
                            end
                            if (32'(alen) < MAX_WORDS) begin
                                a_we = 1'b1;
                                n_wdata[2*LEN_BITS-1:LEN_BITS] = alen + 1'b1;
                            end
                        end
                        in_word_next = 1'b0;
                        cursor_next  = '0;
                        fail_next    = tis_pkg::FAIL_NONE;
                        state_next   = tis_pkg::S_IDLE;
                    end
                end else begin
                    cnt_next   = cnt_sel;
                    idx_next   = '0;
                    state_next = tis_pkg::S_LRD;
                end
            end
            tis_pkg::S_LRD: begin
                l_re       = 1'b1;
                state_next = tis_pkg::S_LOUT;
            end
            tis_pkg::S_LOUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_payload_next.status      = 3'(tis_pkg::ST_FOUND);
                    m_payload_next.word_id     = 16'((mode_reg == tis_pkg::OP_PREFIX)
                                                     ? p_rdata : a_rdata);
                    m_payload_next.last_result = (idx_reg + 1'b1 == cnt_reg);
                    m_payload_next.node_count  = 9'(nodes_reg);
                    m_payload_next.word_count  = 6'(root_len_reg);
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == cnt_reg) begin
                        in_word_next = 1'b0;
                        cursor_next  = '0;
                        fail_next    = tis_pkg::FAIL_NONE;
                        state_next   = tis_pkg::S_IDLE;
                    end else begin
                        state_next = tis_pkg::S_LRD;
                    end
                end
            end
            default: begin
                state_next = tis_pkg::S_IDLE;
            end
        endcase
    end

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_payload)))
        else $error("pending result overwritten");
    a_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        ##1 (nodes_reg == $past(nodes_reg) || nodes_reg == $past(nodes_reg) + 1'b1))
        else $error("node count jumped");
    a_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(nodes_reg) <= MAX_NODES) && (32'(root_len_reg) <= MAX_WORDS))
        else $error("counter beyond capacity");
    a_noclr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tis_pkg::S_CLEAR) |-> !m_valid)
        else $error("result during clearing pass");

endmodule

### hw/rtl/tis_ram.sv
module tis_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int NSYM   = tis_pkg::SYMBOLS_DEF;
    localparam int NNODES = tis_pkg::MAX_NODES_DEF;
    localparam int NWORDS = tis_pkg::MAX_WORDS_DEF;
    localparam int WATCHDOG_LIMIT = 40000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    tis_pkg::in_item_t  s_payload = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    tis_pkg::out_item_t m_payload;

    always #2 aclk = ~aclk;

    trie_insert_and_search_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    // trie mirror
    int        kids [NNODES][NSYM];
    bit [15:0] pfx_ids [NNODES][$];
    bit [15:0] word_ids [NNODES][$];
    int        alloc_nodes;
    int        walk_node;
    bit [1:0]  walk_op;
    bit [15:0] walk_id;
    bit        mid_word;
    bit [2:0]  walk_fail;

    tis_pkg::out_item_t expected_results[$];
    int  mismatches = 0;
    bit  timed_out = 1'b0;
    int  idle_cycles = 0;
    bit  long_hold = 1'b0;

    function automatic tis_pkg::out_item_t mk_result(bit [2:0] st, bit [15:0] id, bit lst);
        tis_pkg::out_item_t r;
        r.status = st;
        r.word_id = id;
        r.last_result = lst;
        r.node_count = 9'(alloc_nodes);
        r.word_count = 6'(pfx_ids[0].size());
        return r;
    endfunction

    function automatic void expect_result(tis_pkg::out_item_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic void add_id(ref bit [15:0] q[$], input bit [15:0] id);
        if (q.size() < NWORDS) q.insert(q.size(), id);
    endfunction

    function automatic void trie_step(tis_pkg::in_item_t it);
        bit ins;
        int nxt;
        int cnt;
        if (!mid_word) begin
            mid_word = 1'b1;
            walk_op = it.operation;
            walk_node = 0;
            walk_fail = tis_pkg::FAIL_NONE;
            walk_id = (it.operation == tis_pkg::OP_INS_GIVEN) ? it.given_id
                                                              : 16'(pfx_ids[0].size());
            if ((it.operation == tis_pkg::OP_INS_GIVEN || it.operation == tis_pkg::OP_INS_AUTO)
                    && pfx_ids[0].size() >= NWORDS)
                walk_fail = tis_pkg::ST_WORDS_FULL;
        end
        ins = (walk_op == tis_pkg::OP_INS_GIVEN || walk_op == tis_pkg::OP_INS_AUTO);
        if (it.has_symbol && it.symbol < NSYM && walk_fail == tis_pkg::FAIL_NONE) begin
            nxt = kids[walk_node][it.symbol];
            if (ins) begin
                if (nxt == 0) begin
                    if (alloc_nodes >= NNODES) begin
                        walk_fail = tis_pkg::ST_NODES_FULL;
                    end else begin
                        nxt = alloc_nodes;
                        kids[walk_node][it.symbol] = nxt;
                        alloc_nodes++;
                    end
                end
                if (walk_fail == tis_pkg::FAIL_NONE) begin
                    add_id(pfx_ids[walk_node], walk_id);
                    walk_node = nxt;
                end
            end else if (nxt == 0) begin
                walk_fail = tis_pkg::ST_NOMATCH;
            end else begin
                walk_node = nxt;
            end
        end
        if (!it.end_of_word) return;
        mid_word = 1'b0;
        if (ins) begin
            if (walk_fail == tis_pkg::FAIL_NONE) begin
                add_id(pfx_ids[walk_node], walk_id);
                add_id(word_ids[walk_node], walk_id);
                expect_result(mk_result(tis_pkg::ST_INSERTED, walk_id, 1'b1));
            end else begin
                expect_result(mk_result(walk_fail, walk_id, 1'b1));
            end
        end else begin
            cnt = 0;
            if (walk_fail == tis_pkg::FAIL_NONE)
                cnt = (walk_op == tis_pkg::OP_PREFIX) ? pfx_ids[walk_node].size()
                                                      : word_ids[walk_node].size();
            if (cnt == 0) begin
                expect_result(mk_result(tis_pkg::ST_NOMATCH, 16'd0, 1'b1));
            end else begin
                for (int i = 0; i < cnt; i++)
                    expect_result(mk_result(tis_pkg::ST_FOUND,
                        (walk_op == tis_pkg::OP_PREFIX) ? pfx_ids[walk_node][i]
                                                        : word_ids[walk_node][i],
                        i == cnt - 1));
            end
        end
        walk_node = 0;
        walk_fail = tis_pkg::FAIL_NONE;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                long_hold = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // result check
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", m_payload);
            end else begin
                tis_pkg::out_item_t e;
                e = expected_results.pop_front();
                if (m_payload !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", e, m_payload);
                end
            end
        end
    end

    // watchdog on accepted handshakes (the clearing pass is covered by the limit)
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Some tests failed");
            $finish;
        end
    end

    // valid stays up after an accept; the next request or drain() decides what follows
    task automatic send_req(tis_pkg::in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_payload <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        trie_step(it);
    endtask

    function automatic tis_pkg::in_item_t mk_req(bit [1:0] op, int sym, bit has, bit eow,
                                                 bit [15:0] id);
        tis_pkg::in_item_t it;
        it.operation = op;
        it.symbol = 5'(sym);
        it.has_symbol = has;
        it.end_of_word = eow;
        it.given_id = id;
        return it;
    endfunction

    task automatic send_word(bit [1:0] op, int len, int alpha, bit [15:0] id);
        for (int i = 0; i < len; i++)
            send_req(mk_req(op, $urandom_range(0, alpha - 1), 1'b1, i == len - 1, id));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    typedef struct {
        tis_pkg::in_item_t  req;
        bit                 check_now;
        tis_pkg::out_item_t want;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic void add_row(dir_row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    initial begin
        int op;
        int n;
        foreach (kids[i, j]) kids[i][j] = 0;
        alloc_nodes = 1;
        walk_node = 0;
        walk_op = '0;
        walk_id = '0;
        mid_word = 1'b0;
        walk_fail = tis_pkg::FAIL_NONE;

        // row: request, check result right away, expected result
        add_row('{mk_req(tis_pkg::OP_EXACT, 0, 1'b0, 1'b1, 16'hFFFF), 1'b1,
            '{tis_pkg::ST_NOMATCH, 16'd0, 1'b1, 9'd1, 6'd0}});
        add_row('{mk_req(tis_pkg::OP_INS_GIVEN, 0, 1'b0, 1'b1, 16'hFFFF), 1'b1,
            '{tis_pkg::ST_INSERTED, 16'hFFFF, 1'b1, 9'd1, 6'd1}});
        add_row('{mk_req(tis_pkg::OP_INS_AUTO, 25, 1'b1, 1'b0, 16'h0), 1'b0, '0});
        add_row('{mk_req(tis_pkg::OP_INS_GIVEN, 0, 1'b1, 1'b0, 16'h1234), 1'b0, '0});
        add_row('{mk_req(tis_pkg::OP_EXACT, 31, 1'b1, 1'b1, 16'h0), 1'b0, '0});
        add_row('{mk_req(tis_pkg::OP_INS_GIVEN, 0, 1'b1, 1'b1, 16'h0000), 1'b0, '0});
        add_row('{mk_req(tis_pkg::OP_PREFIX, 0, 1'b0, 1'b1, 16'h0), 1'b0, '0});
        add_row('{mk_req(tis_pkg::OP_PREFIX, 25, 1'b1, 1'b1, 16'h0), 1'b0, '0});
        add_row('{mk_req(tis_pkg::OP_EXACT, 25, 1'b1, 1'b0, 16'h0), 1'b0, '0});
        add_row('{mk_req(tis_pkg::OP_EXACT, 0, 1'b1, 1'b1, 16'h0), 1'b0, '0});
        add_row('{mk_req(tis_pkg::OP_EXACT, 25, 1'b1, 1'b0, 16'h0), 1'b0, '0});
        add_row('{mk_req(tis_pkg::OP_EXACT, 26, 1'b1, 1'b1, 16'h0), 1'b0, '0});
        add_row('{mk_req(tis_pkg::OP_PREFIX, 3, 1'b1, 1'b0, 16'h0), 1'b0, '0});
        add_row('{mk_req(tis_pkg::OP_PREFIX, 4, 1'b1, 1'b1, 16'h0), 1'b0, '0});
        add_row('{mk_req(tis_pkg::OP_INS_AUTO, 15, 1'b1, 1'b1, 16'hAAAA), 1'b0, '0});
        add_row('{mk_req(tis_pkg::OP_EXACT, 15, 1'b1, 1'b1, 16'h5555), 1'b0, '0});

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            send_req(dir_rows[i].req);
            if (dir_rows[i].check_now) begin
                // check the typed-in result in place of the predicted one
                expected_results[expected_results.size() - 1] = dir_rows[i].want;
                drain();
            end
        end
        drain();

        // receiver holds off while the sender keeps offering
        long_hold = 1'b1;
        for (int w = 0; w < 6; w++)
            send_word(tis_pkg::OP_INS_AUTO, $urandom_range(1, 3), 4, 16'h0);
        send_word(tis_pkg::OP_PREFIX, 1, 4, 16'h0);
        drain();

        n = 0;
        while (n < 230) begin
            op = $urandom_range(0, 99);
            if (op < 8) begin
                send_req(mk_req(2'($urandom), $urandom_range(0, 31), $urandom_range(0, 1),
                                1'b1, 16'($urandom)));
                n++;
            end else if (op < 40) begin
                n += 3;
                send_word(op < 20 ? tis_pkg::OP_INS_GIVEN : tis_pkg::OP_INS_AUTO,
                          $urandom_range(1, 5), (op & 1) ? 26 : 3, 16'($urandom));
            end else begin
                n += 2;
                send_word(op < 70 ? tis_pkg::OP_EXACT : tis_pkg::OP_PREFIX,
                          $urandom_range(1, 3), (op & 1) ? 26 : 3, 16'($urandom));
            end
            if (n > 110 && n < 116) drain();
        end

        // long words with fresh symbols fill the node pool
        while (alloc_nodes < NNODES && pfx_ids[0].size() < NWORDS)
            send_word(tis_pkg::OP_INS_AUTO, 12, 26, 16'h0);
        send_word(tis_pkg::OP_INS_GIVEN, 12, 26, 16'h7777);
        // fill the word table, then overflow it
        while (pfx_ids[0].size() < NWORDS)
            send_word(tis_pkg::OP_INS_GIVEN, 1, 2, 16'($urandom));
        send_word(tis_pkg::OP_INS_AUTO, 2, 2, 16'h0);
        send_req(mk_req(tis_pkg::OP_PREFIX, 0, 1'b0, 1'b1, 16'h0));

        drain();
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
